@@ hw/rtl/ucs2sj_pkg.sv @@
`timescale 1ns / 1ps
package ucs2sj_pkg;

  // table sizes
  localparam int RANGE_SLOTS = 64;
  localparam int MAP_DEPTH   = 8192;
  localparam int SLOT_W      = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int MAP_W       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // queue between lookup and byte emitter, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // opcodes
  localparam logic [1:0] OP_CONVERT = 2'd0;
  localparam logic [1:0] OP_RANGE   = 2'd1;
  localparam logic [1:0] OP_MAP     = 2'd2;

  // register map
  localparam int         PADDR_W         = 2;
  localparam logic [1:0] REG_RANGE_COUNT = 2'd0;

  // jis to shift-jis arithmetic
  localparam logic [7:0] LEAD_OFS   = 8'h70;
  localparam logic [7:0] TRAIL_ODD  = 8'h1f;
  localparam logic [7:0] TRAIL_EVEN = 8'h7d;
  localparam logic [7:0] LEAD_GAP   = 8'ha0;
  localparam logic [7:0] LEAD_SKIP  = 8'h40;
  localparam logic [7:0] TRAIL_GAP  = 8'h7f;

  // one range entry as held in the range memory
  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [12:0] base;
  } range_ent_t;

  // work handed from lookup to emitter
  typedef struct packed {
    logic        single;
    logic [15:0] data;
  } job_t;

  // jis row/cell to lead and trail byte, each wrapping at 8 bits
  function automatic logic [15:0] jis_to_sjis(logic [15:0] jis);
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] lead;
    logic [7:0] trail;
    logic [8:0] half;
    row  = jis[15:8];
    col  = jis[7:0];
    half = '0;
    if (row[0]) begin
      half  = ({1'b0, row} + 9'd1) >> 1;
      lead  = half[7:0] + LEAD_OFS;
      trail = col + TRAIL_ODD;
    end else begin
      lead  = {1'b0, row[7:1]} + LEAD_OFS;
      trail = col + TRAIL_EVEN;
    end
    if (lead >= LEAD_GAP) lead = lead + LEAD_SKIP;
    if (trail >= TRAIL_GAP) trail = trail + 8'd1;
    return {lead, trail};
  endfunction

endpackage

@@ hw/rtl/ucs2sj_if.sv @@
`timescale 1ns / 1ps
// command channel
interface ucs2sj_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] char_code;
  logic [5:0]  range_slot;
  logic [15:0] range_first;
  logic [15:0] range_last;
  logic [12:0] range_base;
  logic [12:0] map_index;
  logic [15:0] map_value;

  modport source (output valid, opcode, char_code, range_slot, range_first, range_last,
                  range_base, map_index, map_value, input ready);
  modport sink (input valid, opcode, char_code, range_slot, range_first, range_last,
                range_base, map_index, map_value, output ready);
endinterface

// byte result channel
interface ucs2sj_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

@@ hw/rtl/ucs2sj_ram.sv @@
`timescale 1ns / 1ps
module ucs2sj_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/ucs2sj_queue.sv @@
`timescale 1ns / 1ps
module ucs2sj_queue
  import ucs2sj_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end

endmodule

@@ hw/rtl/ucs2sj_front.sv @@
`timescale 1ns / 1ps
module ucs2sj_front
  import ucs2sj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ucs2sj_cmd_if.sink         cmd,
  input  logic [6:0]         range_count,
  input  logic               q_full,
  output logic               push,
  output job_t               push_job
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_ADDR   = 2'd2;
  localparam logic [1:0] S_MAPRD  = 2'd3;

  logic [1:0]        state, state_next;
  logic [15:0]       code, code_next;
  logic [SLOT_W-1:0] chk_slot, chk_slot_next;
  logic [15:0]       offset, offset_next;
  logic [12:0]       base, base_next;

  logic              accept;
  logic [SLOT_W:0]   eff_count;
  logic [SLOT_W-1:0] last_slot;
  logic              hit;
  logic [16:0]       map_idx;

  logic              rng_wr_en, rng_rd_en;
  logic [SLOT_W-1:0] rng_rd_addr;
  range_ent_t        rng_wr_data, rng_rd_data;
  logic              map_wr_en, map_rd_en;
  logic [15:0]       map_rd_data;

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE) && !q_full;

  // slots searched, clipped to the table size
  assign eff_count = (32'(range_count) > RANGE_SLOTS) ? (SLOT_W+1)'(RANGE_SLOTS)
                                                      : (SLOT_W+1)'(range_count);
  assign last_slot = SLOT_W'(eff_count - 1'b1);

  // range entry under test and map index of a hit
  assign hit     = (code >= rng_rd_data.first) && (code <= rng_rd_data.last);
  assign map_idx = {4'b0, base} + {1'b0, offset};

  // table loads
  assign rng_wr_en   = accept && (cmd.opcode == OP_RANGE) && (32'(cmd.range_slot) < RANGE_SLOTS);
  assign rng_wr_data = '{first: cmd.range_first, last: cmd.range_last, base: cmd.range_base};
  assign map_wr_en   = accept && (cmd.opcode == OP_MAP) && (32'(cmd.map_index) < MAP_DEPTH);

  ucs2sj_ram #(.WIDTH($bits(range_ent_t)), .DEPTH(RANGE_SLOTS)) u_range_ram (
    .clk     (clk),
    .wr_en   (rng_wr_en),
    .wr_addr (SLOT_W'(cmd.range_slot)),
    .wr_data (rng_wr_data),
    .rd_en   (rng_rd_en),
    .rd_addr (rng_rd_addr),
    .rd_data (rng_rd_data)
  );

  ucs2sj_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (MAP_W'(cmd.map_index)),
    .wr_data (cmd.map_value),
    .rd_en   (map_rd_en),
    .rd_addr (map_idx[MAP_W-1:0]),
    .rd_data (map_rd_data)
  );

  // classify, scan the ranges one slot a cycle, then read the map word
  always_comb begin
    state_next    = state;
    code_next     = code;
    chk_slot_next = chk_slot;
    offset_next   = offset;
    base_next     = base;
    push          = 1'b0;
    push_job      = '{single: 1'b0, data: 16'h0000};
    rng_rd_en     = 1'b0;
    rng_rd_addr   = chk_slot + 1'b1;
    map_rd_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd.opcode == OP_CONVERT)) begin
          if (cmd.char_code[15:8] == 8'h00) begin
            push     = 1'b1;
            push_job = '{single: 1'b1, data: cmd.char_code};
          end else if (eff_count == '0) begin
            push = 1'b1;
          end else begin
            rng_rd_en     = 1'b1;
            rng_rd_addr   = '0;
            chk_slot_next = '0;
            code_next     = cmd.char_code;
            state_next    = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          offset_next = code - rng_rd_data.first;
          base_next   = rng_rd_data.base;
          state_next  = S_ADDR;
        end else if (chk_slot == last_slot) begin
          if (!q_full) begin
            push       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          rng_rd_en     = 1'b1;
          chk_slot_next = chk_slot + 1'b1;
        end
      end
      S_ADDR: begin
        if (32'(map_idx) < MAP_DEPTH) begin
          map_rd_en  = 1'b1;
          state_next = S_MAPRD;
        end else if (!q_full) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MAPRD: begin
        if (!q_full) begin
          push       = 1'b1;
          push_job   = '{single: 1'b0, data: map_rd_data};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search context
  always_ff @(posedge clk) begin
    code     <= code_next;
    chk_slot <= chk_slot_next;
    offset   <= offset_next;
    base     <= base_next;
  end

endmodule

@@ hw/rtl/ucs2sj_back.sv @@
`timescale 1ns / 1ps
module ucs2sj_back
  import ucs2sj_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  job_t          q_job,
  output logic          pop,
  ucs2sj_res_if.source  res
);

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        trail_valid;
  logic [7:0]  trail_byte;
  logic        take;
  logic [15:0] sjis;

  assign res.valid     = out_valid;
  assign res.out_byte  = out_byte;
  assign res.last_byte = last_byte;

  // output register free or emptying this cycle
  assign take = !out_valid || res.ready;
  assign pop  = take && !trail_valid && !q_empty;
  assign sjis = jis_to_sjis(q_job.data);

  // emit lead then trail, or the single byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      trail_valid <= 1'b0;
    end else if (take) begin
      if (trail_valid) begin
        out_valid   <= 1'b1;
        out_byte    <= trail_byte;
        last_byte   <= 1'b1;
        trail_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        if (q_job.single) begin
          out_byte  <= q_job.data[7:0];
          last_byte <= 1'b1;
        end else begin
          out_byte    <= sjis[15:8];
          last_byte   <= 1'b0;
          trail_valid <= 1'b1;
          trail_byte  <= sjis[7:0];
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ucs2_to_shift_jis_converter_unit.sv @@
`timescale 1ns / 1ps
// UCS-2 to Shift-JIS converter.
// cmd channel (valid/ready): opcode 0 converts char_code, opcode 1 loads a
// range entry (slot, first, last, base), opcode 2 loads one map word.
// res channel (valid/ready): one beat per output byte, last_byte marks the
// final byte of a character. Codes below 0x100 give one beat, others two.
// APB register 0 (range_count) sets how many range slots are searched.
// Flow: a code below 0x100 or a load is handled when accepted; a looked-up
// code is accepted, then the range slots are scanned in order up to the
// first hit, the map address is formed and the map word read if the index
// lies inside the map; on a miss every searched slot is scanned, no more.
// The scan through the range memory sets the per-character time; the byte
// emitter then sends a lead and a trail beat for a double-byte character.
// A two-entry queue lets lookup run ahead of the emitter, and cmd is held
// off only while a lookup is in progress or the queue is full.
// When the receiver stalls, the current beat holds and the queue fills.
// Reset clears range_count and all handshake state; the range and map
// memories keep their contents and must be loaded before use.
module ucs2_to_shift_jis_converter_unit
  import ucs2sj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ucs2sj_cmd_if.sink         cmd,
  ucs2sj_res_if.source       res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [6:0] range_count;
  logic       push, pop, q_full, q_empty;
  job_t       push_job, q_job;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_RANGE_COUNT) ? 32'(range_count) : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_RANGE_COUNT)) begin
      range_count <= pwdata[6:0];
    end
  end

  ucs2sj_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .range_count (range_count),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  ucs2sj_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (q_job)
  );

  ucs2sj_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .pop     (pop),
    .res     (res)
  );

endmodule

@@ hw/rtl/ucs2sj_checker.sv @@
`timescale 1ns / 1ps
module ucs2sj_checker
  import ucs2sj_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [7:0]         res_byte,
  input logic               res_last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // no beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_last))
    else $error("stalled result beat changed");

  // a lead byte is followed at once by its trail byte
  a_trail_follows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid && res_last)
    else $error("trail byte did not follow lead byte");

  // range_count reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == REG_RANGE_COUNT)
    |=> (paddr != REG_RANGE_COUNT) || (prdata[6:0] == $past(pwdata[6:0])))
    else $error("range_count readback mismatch");

endmodule

bind ucs2_to_shift_jis_converter_unit ucs2sj_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_byte  (res.out_byte),
  .res_last  (res.last_byte),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
